### design/dpt_pkg.sv
package dpt_pkg;

  // Fixed field widths of the timer.
  localparam int CNT_W  = 16;
  localparam int NS_W   = 33;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // Scale factors for the nanosecond readout.
  localparam logic [NS_W-1:0] NS_PER_TICK = NS_W'(500);
  localparam logic [NS_W-1:0] NS_PER_WRAP = NS_W'(31250000);

  // Register reset values.
  localparam logic [7:0]       PRESCALE_RST = 8'd1;
  localparam logic [CNT_W-1:0] BASE_RST     = CNT_W'(62500);
  localparam logic [7:0]       WPS_RST      = 8'd32;
  localparam logic [CNT_W-1:0] TOP_RST      = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    REG_PRESCALE = 3'd0,
    REG_BASE     = 3'd1,
    REG_WHOLE    = 3'd2,
    REG_FRACTION = 3'd3,
    REG_WPS      = 3'd4
  } cfg_reg_t;

  // Period top for a given phase: base + whole + dither bit, clamped to
  // 1 .. 2^CNT_W, minus one. The dither bit interleaves the high and low
  // fraction nibbles across the 256 phases.
  function automatic logic [CNT_W-1:0] period_top_f(
    input logic [CNT_W-1:0] base,
    input logic [7:0]       whole,
    input logic [7:0]       frac,
    input logic [7:0]       phase
  );
    logic              hi_more;
    logic              extra;
    logic signed [CNT_W+1:0] sum;
    logic [CNT_W+1:0]  sum_m1;
    hi_more = (phase[7:4] < frac[7:4]);
    extra   = ({1'b0, phase[3:0]} < ({1'b0, frac[3:0]} + {4'b0, hi_more}));
    sum     = $signed({2'b00, base}) + (CNT_W+2)'($signed(whole))
              + $signed({{(CNT_W+1){1'b0}}, extra});
    sum_m1  = (CNT_W+2)'(sum) - (CNT_W+2)'(1);
    if (sum < $signed((CNT_W+2)'(1))) begin
      period_top_f = '0;
    end else if (sum > $signed((CNT_W+2)'(1) << CNT_W)) begin
      period_top_f = '1;
    end else begin
      period_top_f = sum_m1[CNT_W-1:0];
    end
  endfunction

endpackage

### design/dithered_period_timer.sv
// The result of an accepted tick is registered. Throughput: one tick per
// cycle while out_stall is low; the result register frees up in the same
// cycle that the downstream side takes it, so ticks stream back to back.
// Reset (rst_n low, synchronous): counters, phase and result valid clear,
// registers take their defaults and the period top returns to all ones.
module dithered_period_timer
  import dpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_tick,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_wrap_pulse,
  output logic              out_second_pulse,
  output logic [CNT_W-1:0]  out_count_now,
  output logic [7:0]        out_wraps_this_second,
  output logic [7:0]        out_seconds_now,
  output logic [7:0]        out_dither_phase,
  output logic [NS_W-1:0]   out_nanoseconds,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // Configuration registers.
  logic [7:0]       prescale_r, prescale_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;
  logic [7:0]       whole_r, whole_nxt;
  logic [7:0]       frac_r, frac_nxt;
  logic [7:0]       wps_r, wps_nxt;

  // Timer state.
  logic [7:0]       pcount_r, pcount_nxt;
  logic [CNT_W-1:0] counter_r, counter_nxt;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [7:0]       wraps_r, wraps_nxt;
  logic [7:0]       secs_r, secs_nxt;
  logic [7:0]       phase_r, phase_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic             wrap_r, wrap_nxt;
  logic             sec_r, sec_nxt;

  logic             accept;
  logic             top_dirty;
  logic [7:0]       pcount_inc;
  logic [CNT_W:0]   counter_inc;
  logic [7:0]       wraps_inc;

  // The input waits only while an untaken result sits in the register.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pcount_inc  = pcount_r + 8'd1;
  assign counter_inc = {1'b0, counter_r} + (CNT_W+1)'(1);
  assign wraps_inc   = wraps_r + 8'd1;

  // Register writes and the per-tick state update.
  always_comb begin
    prescale_nxt  = prescale_r;
    base_nxt      = base_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    wps_nxt       = wps_r;
    pcount_nxt    = pcount_r;
    counter_nxt   = counter_r;
    wraps_nxt     = wraps_r;
    secs_nxt      = secs_r;
    phase_nxt     = phase_r;
    wrap_nxt      = wrap_r;
    sec_nxt       = sec_r;
    top_dirty     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESCALE: prescale_nxt = cfg_wdata[7:0];
        REG_BASE: begin
          base_nxt  = cfg_wdata[CNT_W-1:0];
          top_dirty = 1'b1;
        end
        REG_WHOLE: begin
          whole_nxt = cfg_wdata[7:0];
          top_dirty = 1'b1;
        end
        REG_FRACTION: begin
          frac_nxt  = cfg_wdata[7:0];
          top_dirty = 1'b1;
        end
        REG_WPS:  wps_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      wrap_nxt      = 1'b0;
      sec_nxt       = 1'b0;
      if (in_tick) begin
        pcount_nxt = pcount_inc;
        if (pcount_inc == prescale_r) begin
          pcount_nxt = '0;
          if (counter_inc > {1'b0, top_r}) begin
            counter_nxt = '0;
            wrap_nxt    = 1'b1;
            wraps_nxt   = wraps_inc;
            if (wraps_inc == wps_r) begin
              wraps_nxt = '0;
              secs_nxt  = secs_r + 8'd1;
              sec_nxt   = 1'b1;
            end
            phase_nxt = phase_r + 8'd1;
            top_dirty = 1'b1;
          end else begin
            counter_nxt = counter_inc[CNT_W-1:0];
          end
        end
      end
    end

    top_nxt = top_dirty ? period_top_f(base_nxt, whole_nxt, frac_nxt, phase_nxt) : top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= PRESCALE_RST;
      base_r      <= BASE_RST;
      whole_r     <= '0;
      frac_r      <= '0;
      wps_r       <= WPS_RST;
      pcount_r    <= '0;
      counter_r   <= '0;
      top_r       <= TOP_RST;
      wraps_r     <= '0;
      secs_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      wrap_r      <= 1'b0;
      sec_r       <= 1'b0;
    end else begin
      prescale_r  <= prescale_nxt;
      base_r      <= base_nxt;
      whole_r     <= whole_nxt;
      frac_r      <= frac_nxt;
      wps_r       <= wps_nxt;
      pcount_r    <= pcount_nxt;
      counter_r   <= counter_nxt;
      top_r       <= top_nxt;
      wraps_r     <= wraps_nxt;
      secs_r      <= secs_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      wrap_r      <= wrap_nxt;
      sec_r       <= sec_nxt;
    end
  end

  // The state registers hold exactly the values after the last tick, so
  // they double as the result payload.
  assign out_valid             = out_valid_r;
  assign out_wrap_pulse        = wrap_r;
  assign out_second_pulse      = sec_r;
  assign out_count_now         = counter_r;
  assign out_wraps_this_second = wraps_r;
  assign out_seconds_now       = secs_r;
  assign out_dither_phase      = phase_r;

  // Nanosecond readout from the registered counts, modulo 2^NS_W.
  assign out_nanoseconds = (NS_W'(wraps_r) * NS_PER_WRAP)
                         + (NS_W'(counter_r) * NS_PER_TICK);

`ifndef SYNTHESIS
  // A second boundary always coincides with a counter wrap.
  a_sec_has_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sec_r |-> wrap_r)
    else $error("second pulse without wrap pulse");

  // A wrap always leaves the counter at zero.
  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && wrap_r |-> counter_r == '0)
    else $error("counter not zero after wrap");

  // A stalled result keeps the state frozen for the next cycle.
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !cfg_we |=> $stable(counter_r) && $stable(phase_r) && $stable(wraps_r))
    else $error("state changed while result was stalled");
`endif

endmodule

### sim/tb_dithered_period_timer.sv
`timescale 1ns / 1ps

module tb_dithered_period_timer;
  import dpt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int MAX_IDLE    = 6;

  // One result transaction of the timer.
  typedef struct packed {
    logic             wrap;
    logic             sec;
    logic [CNT_W-1:0] count;
    logic [7:0]       wraps;
    logic [7:0]       secs;
    logic [7:0]       phase;
    logic [NS_W-1:0]  ns;
  } timer_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_tick;
  logic              out_valid;
  logic              out_stall;
  logic              out_wrap_pulse;
  logic              out_second_pulse;
  logic [CNT_W-1:0]  out_count_now;
  logic [7:0]        out_wraps_this_second;
  logic [7:0]        out_seconds_now;
  logic [7:0]        out_dither_phase;
  logic [NS_W-1:0]   out_nanoseconds;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  dithered_period_timer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_tick               (in_tick),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_wrap_pulse        (out_wrap_pulse),
    .out_second_pulse      (out_second_pulse),
    .out_count_now         (out_count_now),
    .out_wraps_this_second (out_wraps_this_second),
    .out_seconds_now       (out_seconds_now),
    .out_dither_phase      (out_dither_phase),
    .out_nanoseconds       (out_nanoseconds),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // Shadow copy of the timer registers and state.
  logic [7:0]       shadow_div;
  logic [CNT_W-1:0] shadow_base;
  logic [7:0]       shadow_whole;
  logic [7:0]       shadow_frac;
  logic [7:0]       shadow_wps;
  logic [7:0]       shadow_pre;
  logic [CNT_W-1:0] shadow_count;
  logic [CNT_W-1:0] shadow_top;
  logic [7:0]       shadow_wraps;
  logic [7:0]       shadow_secs;
  logic [7:0]       shadow_phase;

  timer_result_t pending_results[$];
  timer_result_t last_pred;
  timer_result_t want;
  timer_result_t got;

  bit idle_en;
  int stall_left;
  int cycle_count;
  int mismatch_count;
  int error_count;
  int result_count;
  int tick_count;
  int wrap_seen;
  int second_seen;
  int write_count;

  // Period top for the current phase: base plus signed whole adjustment plus
  // the dither bit, clamped to one full counter range.
  function automatic logic [CNT_W-1:0] dithered_top();
    int hi_more;
    int extra;
    int period;
    hi_more = (shadow_phase[7:4] < shadow_frac[7:4]) ? 1 : 0;
    extra   = (int'(shadow_phase[3:0]) < int'(shadow_frac[3:0]) + hi_more) ? 1 : 0;
    period  = int'(shadow_base) + int'($signed(shadow_whole)) + extra;
    if (period < 1) period = 1;
    if (period > (1 << CNT_W)) period = 1 << CNT_W;
    return CNT_W'(period - 1);
  endfunction

  // Advance the shadow timer by one tick transaction and form its result.
  function automatic timer_result_t next_tick_result(logic tick);
    timer_result_t r;
    logic [CNT_W:0] nxt;
    r.wrap = 1'b0;
    r.sec  = 1'b0;
    if (tick) begin
      shadow_pre = shadow_pre + 8'd1;
      if (shadow_pre == shadow_div) begin
        shadow_pre = '0;
        nxt = {1'b0, shadow_count} + 1'b1;
        if (nxt > {1'b0, shadow_top}) begin
          shadow_count = '0;
          r.wrap = 1'b1;
          shadow_wraps = shadow_wraps + 8'd1;
          if (shadow_wraps == shadow_wps) begin
            shadow_secs  = shadow_secs + 8'd1;
            shadow_wraps = '0;
            r.sec = 1'b1;
          end
          shadow_phase = shadow_phase + 8'd1;
          shadow_top = dithered_top();
        end else begin
          shadow_count = nxt[CNT_W-1:0];
        end
      end
    end
    r.count = shadow_count;
    r.wraps = shadow_wraps;
    r.secs  = shadow_secs;
    r.phase = shadow_phase;
    r.ns    = NS_W'(shadow_wraps) * NS_PER_WRAP + NS_W'(shadow_count) * NS_PER_TICK;
    return r;
  endfunction

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result checker: every accepted result is compared with the oldest
  // prediction, and the receiver then draws its next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.wrap  = out_wrap_pulse;
      got.sec   = out_second_pulse;
      got.count = out_count_now;
      got.wraps = out_wraps_this_second;
      got.secs  = out_seconds_now;
      got.phase = out_dither_phase;
      got.ns    = out_nanoseconds;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("Unexpected result transaction at cycle %0d", cycle_count);
      end else begin
        want = pending_results.pop_front();
        if (got.wrap !== want.wrap || got.sec !== want.sec || got.count !== want.count ||
            got.wraps !== want.wraps || got.secs !== want.secs ||
            got.phase !== want.phase || got.ns !== want.ns) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch on result %0d: expected wrap=%0b sec=%0b count=%0d",
                     result_count, want.wrap, want.sec, want.count);
            $display("  wraps=%0d secs=%0d phase=%0d ns=%0d", want.wraps, want.secs,
                     want.phase, want.ns);
            $display("  got wrap=%0b sec=%0b count=%0d wraps=%0d secs=%0d phase=%0d ns=%0d",
                     got.wrap, got.sec, got.count, got.wraps, got.secs, got.phase, got.ns);
          end
        end
      end
      result_count++;
      stall_left = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    end
  end

  // Receiver stall, changed at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Send one tick transaction, after a random gap when idle_en is set, and record its prediction.
  task automatic send_tick(logic tick);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_tick  <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_pred = next_tick_result(tick);
    pending_results.push_back(last_pred);
    tick_count++;
    if (last_pred.wrap) wrap_seen++;
    if (last_pred.sec) second_seen++;
  endtask

  // Stop sending and wait for every predicted result to arrive.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, issued only once the timer is idle.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PRESCALE: shadow_div = data[7:0];
      REG_BASE: begin
        shadow_base = data;
        shadow_top  = dithered_top();
      end
      REG_WHOLE: begin
        shadow_whole = data[7:0];
        shadow_top   = dithered_top();
      end
      REG_FRACTION: begin
        shadow_frac = data[7:0];
        shadow_top  = dithered_top();
      end
      REG_WPS: shadow_wps = data[7:0];
      default: ;
    endcase
    write_count++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Ticks and idle cycles straight out of reset.
  task automatic test_reset_state();
    idle_en = 1'b1;
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // The reset top is all ones, so a burst of counts runs with no wrap;
  // drive it back to back with no idling on either side.
  task automatic test_full_period();
    idle_en = 1'b0;
    repeat (40) send_tick(1'b1);
    idle_en = 1'b1;
  endtask

  // Lowering the top below the running counter makes the next count wrap.
  task automatic test_top_below_count();
    write_reg(REG_BASE, 16'd65408);
    repeat (20) send_tick(1'b1);
    write_reg(REG_WHOLE, 16'h0080);
    write_reg(REG_BASE, 16'd129);
    repeat (3) send_tick(1'b1);
  endtask

  // A divisor lowered below the prescaler count is reached only after the
  // count wraps around.
  task automatic test_prescale_lowered();
    write_reg(REG_PRESCALE, 16'd200);
    repeat (60) send_tick(1'b1);
    write_reg(REG_PRESCALE, 16'd10);
    repeat (260) send_tick($urandom_range(0, 7) != 0);
  endtask

  // Register extremes and writes to indexes past the register list.
  task automatic test_register_extremes();
    write_reg(REG_PRESCALE, 16'd1);
    write_reg(REG_WPS, 16'd1);
    repeat (5) send_tick(1'b1);
    write_reg(REG_WPS, 16'd255);
    write_reg(REG_WHOLE, 16'h007F);
    write_reg(REG_FRACTION, 16'h00FF);
    repeat (5) send_tick(1'b1);
    write_reg(REG_PRESCALE, 16'd255);
    repeat (3) send_tick(1'b1);
    write_reg(REG_PRESCALE, 16'd1);
    for (int r = REG_WPS + 1; r < (1 << CFG_IW); r++) begin
      write_reg(CFG_IW'(r), CFG_DW'($urandom));
    end
    repeat (2) send_tick(1'b1);
    write_reg(REG_BASE, 16'd65408);
    write_reg(REG_FRACTION, 16'h0000);
    write_reg(REG_WHOLE, 16'h0000);
    repeat (3) send_tick(1'b1);
  endtask

  // Random settings, mostly short periods so that wraps and seconds come
  // often; each setting pauses once for all results to drain.
  task automatic test_random_settings();
    int n_items;
    int pause_at;
    int pick;
    for (int ph = 0; ph < 13; ph++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if (ph == 0 || $urandom_range(0, 1) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) write_reg(REG_PRESCALE, 16'd1);
        else if (pick < 8) write_reg(REG_PRESCALE, CFG_DW'($urandom_range(2, 4)));
        else if (pick < 9) write_reg(REG_PRESCALE, CFG_DW'($urandom_range(1, 255)));
        else write_reg(REG_PRESCALE, 16'd255);
      end
      if (ph == 0 || $urandom_range(0, 1) != 0) begin
        pick = $urandom_range(0, 7);
        if (pick < 6) write_reg(REG_BASE, CFG_DW'($urandom_range(129, 189)));
        else if (pick < 7) write_reg(REG_BASE, CFG_DW'($urandom_range(129, 65408)));
        else write_reg(REG_BASE, 16'd65408);
      end
      if (ph == 0 || $urandom_range(0, 1) != 0) begin
        if ($urandom_range(0, 1) != 0) write_reg(REG_WHOLE, CFG_DW'($urandom_range(128, 143)));
        else write_reg(REG_WHOLE, CFG_DW'($urandom_range(0, 255)));
      end
      if (ph == 0 || $urandom_range(0, 1) != 0) begin
        write_reg(REG_FRACTION, CFG_DW'($urandom_range(0, 255)));
      end
      if (ph == 0 || $urandom_range(0, 1) != 0) begin
        if ($urandom_range(0, 5) != 0) write_reg(REG_WPS, CFG_DW'($urandom_range(1, 4)));
        else write_reg(REG_WPS, CFG_DW'($urandom_range(1, 255)));
      end
      n_items  = 80;
      pause_at = $urandom_range(0, n_items - 1);
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) drain_results();
        send_tick($urandom_range(0, 9) != 0);
      end
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    in_tick   = 1'b0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    idle_en   = 1'b0;
    stall_left = 0;

    shadow_div   = PRESCALE_RST;
    shadow_base  = BASE_RST;
    shadow_whole = '0;
    shadow_frac  = '0;
    shadow_wps   = WPS_RST;
    shadow_pre   = '0;
    shadow_count = '0;
    shadow_top   = TOP_RST;
    shadow_wraps = '0;
    shadow_secs  = '0;
    shadow_phase = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_full_period();
    test_top_below_count();
    test_prescale_lowered();
    test_register_extremes();
    test_random_settings();

    // Let the last results arrive, then a few more cycles for stragglers.
    idle_en = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0d predicted results never arrived", pending_results.size());
    end

    $display("Run covered %0d tick transactions with %0d wraps and %0d seconds,",
             tick_count, wrap_seen, second_seen);
    $display("across %0d register writes; %0d mismatches, %0d other errors.",
             write_count, mismatch_count, error_count);
    if (mismatch_count == 0 && error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
